/* rtl/core/three_point_tangent_estimator_core_defines.svh */
// assertion macros for the three point tangent estimator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef THREE_POINT_TANGENT_ESTIMATOR_CORE_DEFINES_SVH
`define THREE_POINT_TANGENT_ESTIMATOR_CORE_DEFINES_SVH

// same cycle implication
`define TPTE_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpte check failed");

// next cycle implication
`define TPTE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpte check failed");

`endif

/* rtl/core/tpte_pkg.sv */
// shared types, widths and helper functions of the tangent estimator
// no dependencies
`default_nettype none

package tpte_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = DIFF_W;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int SHORT_B = 18;
    localparam int SS_W    = 2 * SHORT_B + 2;
    localparam int THR_W   = 2 * (CFG_W + 1);
    localparam int SCL_B   = 20;
    localparam int K_W     = $clog2(MAG_W - SCL_B + 1);
    localparam int SC_W    = SCL_B + 1;
    localparam int NN_W    = 2 * SCL_B + 2;
    localparam int VEC_W   = NN_W + 1 + SC_W;
    localparam int VM_W    = VEC_W - 1;
    localparam int POS_W   = $clog2(VM_W);
    localparam int NM_B    = 30;
    localparam int SQ_W    = 2 * NM_B + 2;
    localparam int ROOT_W  = NM_B + 1;
    localparam int Q_W     = NM_B + 1;
    localparam int DR_W    = ROOT_W + Q_W;
    localparam int TAN_W   = 32;

    localparam logic [IDX_W-1:0] REG_MIN_LEN  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_MIN_NORM = IDX_W'(1);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BOTH_SHORT = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd2;

    localparam logic [CFG_W-1:0] MIN_LEN_RST  = CFG_W'(7);
    localparam logic [CFG_W-1:0] MIN_NORM_RST = CFG_W'(1);

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << NM_B;
    localparam logic signed [TAN_W-1:0] TAN_ONE       = TAN_W'(ONE_Q);
    localparam logic signed [TAN_W-1:0] TAN_MINUS_ONE = -TAN_ONE;

    typedef struct packed {
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p1_z;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p2_z;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic signed [COORD_W-1:0] p3_z;
    } t_in_item;

    typedef struct packed {
        logic signed [TAN_W-1:0] tan_x;
        logic signed [TAN_W-1:0] tan_y;
        logic signed [TAN_W-1:0] tan_z;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] min_len;
        logic [CFG_W-1:0] min_norm;
    } t_cfg;

    typedef logic [2:0][MAG_W-1:0] t_mag3;

    typedef struct packed {
        logic [2:0][VEC_W-1:0] v;
        logic [1:0]            status;
    } t_vec_item;

    typedef struct packed {
        logic [2:0][NM_B-1:0] m;
        logic [2:0]           neg;
        logic [1:0]           status;
    } t_nrm_side;

    function automatic logic [MAG_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] n;
        n = d[DIFF_W-1] ? (~d + 1'b1) : d;
        return MAG_W'(n);
    endfunction

    // all three magnitudes below 2^SHORT_B
    function automatic logic all_short(input t_mag3 m);
        return ~|{m[0][MAG_W-1:SHORT_B], m[1][MAG_W-1:SHORT_B], m[2][MAG_W-1:SHORT_B]};
    endfunction

    function automatic logic [SS_W-1:0] sum_sq_short(input t_mag3 m);
        logic [2*SHORT_B-1:0] sq [3];
        for (int i = 0; i < 3; i++) begin
            sq[i] = m[i][SHORT_B-1:0] * m[i][SHORT_B-1:0];
        end
        return SS_W'(sq[0]) + SS_W'(sq[1]) + SS_W'(sq[2]);
    endfunction

    function automatic logic [NN_W-1:0] sum_sq_sc(input logic [2:0][SC_W-1:0] s);
        logic signed [NN_W-1:0] p [3];
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(s[i]) * $signed(s[i]);
        end
        return NN_W'(p[0] + p[1] + p[2]);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/three_point_tangent_estimator_core.sv */
// Three point tangent estimator, top level.
// Input channel (i_in_valid / o_in_ready / i_in_data): one request carries three
// signed Q16.16 points; the result is the unit tangent at the middle point in Q1.30
// plus a status code (ok, both chords short, tangent too short; zero tangent on fail).
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per request,
// in request order.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): index 0 is
// min_len, index 1 is min_norm, other indexes are dropped; write only while idle.
// From acceptance to o_out_valid a request passes 6 front stages, 4 normalize
// stages, 31 square root stages, 31 divider stages and the output register.
// Throughput is one request per cycle while the output is not stalled; the square
// root and divider are fully pipelined, one bit per stage.
// A stalled receiver holds the whole pipeline: o_in_ready drops while a result waits
// in the output register and i_out_ready is low, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets min_len to 7 and
// min_norm to 1.
// depends on tpte_pkg and the tpte_* submodules
`default_nettype none

module three_point_tangent_estimator_core import tpte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len  <= MIN_LEN_RST;
            r_cfg.min_norm <= MIN_NORM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_LEN:  r_cfg.min_len  <= i_cfg_data;
                REG_MIN_NORM: r_cfg.min_norm <= i_cfg_data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // whole pipeline advances unless a finished result is held
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    logic              w_f_v;
    t_vec_item         w_f_item;
    logic              w_n_v;
    logic [SQ_W-1:0]   w_n_sum;
    t_nrm_side         w_n_side;
    logic              w_s_v;
    logic [ROOT_W-1:0] w_s_root;
    t_nrm_side         w_s_side;

    tpte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_f_v),
        .o_item  (w_f_item)
    );

    tpte_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_item  (w_f_item),
        .o_valid (w_n_v),
        .o_sum   (w_n_sum),
        .o_side  (w_n_side)
    );

    tpte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_n_v),
        .i_sum   (w_n_sum),
        .i_side  (w_n_side),
        .o_valid (w_s_v),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    tpte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_v),
        .i_len   (w_s_root),
        .i_side  (w_s_side),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/core/tpte_front.sv */
// front stages: chord differences, short tests, common scaling, direction vector
// depends on tpte_pkg
`default_nettype none

module tpte_front import tpte_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_vec_item o_item
);

    logic signed [COORD_W-1:0] w_p1 [3], w_p2 [3], w_p3 [3];

    assign w_p1[0] = i_item.p1_x;
    assign w_p1[1] = i_item.p1_y;
    assign w_p1[2] = i_item.p1_z;
    assign w_p2[0] = i_item.p2_x;
    assign w_p2[1] = i_item.p2_y;
    assign w_p2[2] = i_item.p2_z;
    assign w_p3[0] = i_item.p3_x;
    assign w_p3[1] = i_item.p3_y;
    assign w_p3[2] = i_item.p3_z;

    // stage a: exact differences
    logic signed [DIFF_W-1:0] n_a_a [3], n_a_b [3], n_a_e [3];
    logic signed [DIFF_W-1:0] r_a_a [3], r_a_b [3], r_a_e [3];
    logic                     r_a_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_a[i] = $signed({w_p2[i][COORD_W-1], w_p2[i]})
                     - $signed({w_p1[i][COORD_W-1], w_p1[i]});
            n_a_b[i] = $signed({w_p3[i][COORD_W-1], w_p3[i]})
                     - $signed({w_p2[i][COORD_W-1], w_p2[i]});
            n_a_e[i] = $signed({w_p3[i][COORD_W-1], w_p3[i]})
                     - $signed({w_p1[i][COORD_W-1], w_p1[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_a <= n_a_a;
            r_a_b <= n_a_b;
            r_a_e <= n_a_e;
        end
    end

    // stage b: magnitudes, squared lengths of short candidates, largest magnitude
    t_mag3             w_ma, w_mb, w_me;
    logic [MAG_W-1:0]  n_b_mx;
    logic signed [DIFF_W-1:0] r_b_a [3], r_b_b [3], r_b_e [3];
    logic [SS_W-1:0]   r_b_ssa, r_b_ssb, r_b_sse;
    logic              r_b_sma, r_b_smb, r_b_sme;
    logic [MAG_W-1:0]  r_b_mx;
    logic              r_b_v;

    always_comb begin
        n_b_mx = '0;
        for (int i = 0; i < 3; i++) begin
            w_ma[i] = diff_mag(r_a_a[i]);
            w_mb[i] = diff_mag(r_a_b[i]);
            w_me[i] = diff_mag(r_a_e[i]);
        end
        for (int i = 0; i < 3; i++) begin
            if (w_ma[i] > n_b_mx) n_b_mx = w_ma[i];
            if (w_mb[i] > n_b_mx) n_b_mx = w_mb[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_a   <= r_a_a;
            r_b_b   <= r_a_b;
            r_b_e   <= r_a_e;
            r_b_ssa <= sum_sq_short(w_ma);
            r_b_ssb <= sum_sq_short(w_mb);
            r_b_sse <= sum_sq_short(w_me);
            r_b_sma <= all_short(w_ma);
            r_b_smb <= all_short(w_mb);
            r_b_sme <= all_short(w_me);
            r_b_mx  <= n_b_mx;
        end
    end

    // stage c: threshold compares, case decision, scale shift
    logic [2*CFG_W-1:0] w_ml2, w_mn2;
    logic [THR_W-1:0]   w_mn4;
    logic               w_s1, w_s2, w_fail;
    logic [1:0]         n_c_st;
    logic [K_W-1:0]     n_c_k;
    logic signed [DIFF_W-1:0] r_c_a [3], r_c_b [3], r_c_e [3];
    logic [1:0]         r_c_st;
    logic               r_c_s1, r_c_gen;
    logic [K_W-1:0]     r_c_k;
    logic               r_c_v;

    always_comb begin
        w_ml2  = i_cfg.min_len * i_cfg.min_len;
        w_mn2  = i_cfg.min_norm * i_cfg.min_norm;
        w_mn4  = {w_mn2, 2'b00};
        w_s1   = r_b_sma && (r_b_ssa < SS_W'(w_ml2));
        w_s2   = r_b_smb && (r_b_ssb < SS_W'(w_ml2));
        w_fail = 1'b0;
        if (w_s1) begin
            w_fail = r_b_sme && (r_b_sse < SS_W'(w_mn2));
        end else if (w_s2) begin
            w_fail = r_b_sma && (r_b_ssa < SS_W'(w_mn2));
        end else begin
            w_fail = r_b_sme && (r_b_sse < SS_W'(w_mn4));
        end
        if (w_s1 && w_s2) begin
            n_c_st = ST_BOTH_SHORT;
        end else if (w_fail) begin
            n_c_st = ST_TOO_SHORT;
        end else begin
            n_c_st = ST_OK;
        end
        // smallest shift that brings the largest magnitude under 2^20
        n_c_k = '0;
        for (int b = SCL_B; b < MAG_W; b++) begin
            if (r_b_mx[b]) n_c_k = K_W'(b - SCL_B + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_a   <= r_b_a;
            r_c_b   <= r_b_b;
            r_c_e   <= r_b_e;
            r_c_st  <= n_c_st;
            r_c_s1  <= w_s1;
            r_c_gen <= !w_s1 && !w_s2;
            r_c_k   <= n_c_k;
        end
    end

    // stage d: scaled chords, fallback direction
    logic [2:0][SC_W-1:0] n_d_sa, n_d_sb;
    logic [MAG_W-1:0]     w_mga, w_mgb;
    logic [SC_W-1:0]      w_ua, w_ub;
    logic [2:0][SC_W-1:0] r_d_sa, r_d_sb;
    logic signed [DIFF_W-1:0] r_d_alt [3];
    logic [1:0]           r_d_st;
    logic                 r_d_gen;
    logic                 r_d_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mga = diff_mag(r_c_a[i]) >> r_c_k;
            w_mgb = diff_mag(r_c_b[i]) >> r_c_k;
            w_ua  = {1'b0, w_mga[SCL_B-1:0]};
            w_ub  = {1'b0, w_mgb[SCL_B-1:0]};
            n_d_sa[i] = r_c_a[i][DIFF_W-1] ? (~w_ua + 1'b1) : w_ua;
            n_d_sb[i] = r_c_b[i][DIFF_W-1] ? (~w_ub + 1'b1) : w_ub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_sa  <= n_d_sa;
            r_d_sb  <= n_d_sb;
            for (int i = 0; i < 3; i++) begin
                r_d_alt[i] <= r_c_s1 ? r_c_e[i] : r_c_a[i];
            end
            r_d_st  <= r_c_st;
            r_d_gen <= r_c_gen;
        end
    end

    // stage e: squared scaled lengths
    logic [NN_W-1:0]      r_e_na, r_e_nb;
    logic [2:0][SC_W-1:0] r_e_sa, r_e_sb;
    logic signed [DIFF_W-1:0] r_e_alt [3];
    logic [1:0]           r_e_st;
    logic                 r_e_gen;
    logic                 r_e_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_na  <= sum_sq_sc(r_d_sa);
            r_e_nb  <= sum_sq_sc(r_d_sb);
            r_e_sa  <= r_d_sa;
            r_e_sb  <= r_d_sb;
            r_e_alt <= r_d_alt;
            r_e_st  <= r_d_st;
            r_e_gen <= r_d_gen;
        end
    end

    // stage f: w = |b|^2 a + |a|^2 b
    logic signed [VEC_W-1:0] w_pa, w_pb;
    t_vec_item               n_f_item;
    t_vec_item               r_f_item;
    logic                    r_f_v;

    always_comb begin
        n_f_item.status = r_e_st;
        for (int i = 0; i < 3; i++) begin
            w_pa = $signed({1'b0, r_e_nb}) * $signed(r_e_sa[i]);
            w_pb = $signed({1'b0, r_e_na}) * $signed(r_e_sb[i]);
            n_f_item.v[i] = r_e_gen ? (w_pa + w_pb) : VEC_W'(r_e_alt[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_item <= n_f_item;
        end
    end

    assign o_valid = r_f_v;
    assign o_item  = r_f_item;

endmodule

`default_nettype wire

/* rtl/core/tpte_norm.sv */
// normalizing stages: magnitudes, leading one, shift into [2^29, 2^30), sum of squares
// depends on tpte_pkg
`default_nettype none

module tpte_norm import tpte_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_vec_item       i_item,
    output logic            o_valid,
    output logic [SQ_W-1:0] o_sum,
    output t_nrm_side       o_side
);

    // stage g: magnitudes and zero check
    logic [VEC_W-1:0]     w_full;
    logic [2:0][VM_W-1:0] n_g_m;
    logic [2:0]           n_g_neg;
    logic [VM_W-1:0]      n_g_mx;
    logic [1:0]           n_g_st;
    logic [2:0][VM_W-1:0] r_g_m;
    logic [2:0]           r_g_neg;
    logic [VM_W-1:0]      r_g_mx;
    logic [1:0]           r_g_st;
    logic                 r_g_v;

    always_comb begin
        n_g_mx = '0;
        for (int i = 0; i < 3; i++) begin
            n_g_neg[i] = i_item.v[i][VEC_W-1];
            w_full     = n_g_neg[i] ? (~i_item.v[i] + 1'b1) : i_item.v[i];
            n_g_m[i]   = w_full[VM_W-1:0];
            if (n_g_m[i] > n_g_mx) n_g_mx = n_g_m[i];
        end
        n_g_st = i_item.status;
        if (i_item.status == ST_OK && n_g_mx == '0) begin
            n_g_st = ST_TOO_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_g_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_m   <= n_g_m;
            r_g_neg <= n_g_neg;
            r_g_mx  <= n_g_mx;
            r_g_st  <= n_g_st;
        end
    end

    // stage h: leading one and shift amount
    logic [POS_W-1:0]     n_h_pos;
    logic [2:0][VM_W-1:0] r_h_m;
    logic [2:0]           r_h_neg;
    logic [1:0]           r_h_st;
    logic                 r_h_rsh;
    logic [POS_W-1:0]     r_h_amt;
    logic                 r_h_v;

    always_comb begin
        n_h_pos = '0;
        for (int b = 0; b < VM_W; b++) begin
            if (r_g_mx[b]) n_h_pos = POS_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (i_en) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h_m   <= r_g_m;
            r_h_neg <= r_g_neg;
            r_h_st  <= r_g_st;
            r_h_rsh <= n_h_pos > POS_W'(NM_B - 1);
            r_h_amt <= (n_h_pos > POS_W'(NM_B - 1)) ? (n_h_pos - POS_W'(NM_B - 1))
                                                    : (POS_W'(NM_B - 1) - n_h_pos);
        end
    end

    // stage i: apply the common shift, right shift truncates
    logic [VM_W-1:0]      w_sh;
    logic [2:0][NM_B-1:0] n_i_m;
    logic [2:0][NM_B-1:0] r_i_m;
    logic [2:0]           r_i_neg;
    logic [1:0]           r_i_st;
    logic                 r_i_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh     = r_h_rsh ? (r_h_m[i] >> r_h_amt) : (r_h_m[i] << r_h_amt);
            n_i_m[i] = w_sh[NM_B-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (i_en) begin
            r_i_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i_m   <= n_i_m;
            r_i_neg <= r_h_neg;
            r_i_st  <= r_h_st;
        end
    end

    // stage j: sum of squares
    logic [2*NM_B-1:0] w_sq [3];
    logic [SQ_W-1:0]   r_j_s;
    t_nrm_side         r_j_side;
    logic              r_j_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = r_i_m[i] * r_i_m[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else if (i_en) begin
            r_j_v <= r_i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_j_s           <= SQ_W'(w_sq[0]) + SQ_W'(w_sq[1]) + SQ_W'(w_sq[2]);
            r_j_side.m      <= r_i_m;
            r_j_side.neg    <= r_i_neg;
            r_j_side.status <= r_i_st;
        end
    end

    assign o_valid = r_j_v;
    assign o_sum   = r_j_s;
    assign o_side  = r_j_side;

endmodule

`default_nettype wire

/* rtl/core/tpte_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on tpte_pkg
`default_nettype none

module tpte_sqrt import tpte_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_sum,
    input  t_nrm_side         i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_nrm_side         o_side
);

    logic              r_v    [ROOT_W];
    logic [SQ_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_nrm_side         r_side [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;

        logic              w_v;
        logic [SQ_W-1:0]   w_rem;
        logic [ROOT_W-1:0] w_root;
        t_nrm_side         w_side;
        logic [SQ_W+1:0]   w_trial;
        logic              w_take;

        if (j == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_sum;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
            assign w_side = r_side[j-1];
        end

        // (r + 2^b)^2 - r^2 with r holding only bits above b
        assign w_trial = ((SQ_W+2)'(w_root) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
        assign w_take  = {2'b00, w_rem} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_take ? (w_rem - w_trial[SQ_W-1:0]) : w_rem;
                r_root[j] <= w_root | (w_take ? (ROOT_W'(1) << B) : '0);
                r_side[j] <= w_side;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/core/tpte_div.sv */
// three lane pipelined restoring divider m * 2^30 / len, then sign and output register
// depends on tpte_pkg
`default_nettype none

module tpte_div import tpte_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_len,
    input  t_nrm_side         i_side,
    output logic              o_valid,
    output t_out_item         o_item
);

    logic              r_v    [Q_W];
    logic [ROOT_W-1:0] r_len  [Q_W];
    t_nrm_side         r_side [Q_W];
    logic [DR_W-1:0]   r_rem  [Q_W][3];
    logic [Q_W-1:0]    r_q    [Q_W][3];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int B = Q_W - 1 - j;

        logic              w_v;
        logic [ROOT_W-1:0] w_len;
        t_nrm_side         w_side;
        logic [DR_W-1:0]   w_rem [3];
        logic [Q_W-1:0]    w_q   [3];
        logic [DR_W-1:0]   w_dv;

        if (j == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_len  = i_len;
            assign w_side = i_side;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem[l] = DR_W'(i_side.m[l]) << NM_B;
                assign w_q[l]   = '0;
            end
        end else begin : g_next
            assign w_v    = r_v[j-1];
            assign w_len  = r_len[j-1];
            assign w_side = r_side[j-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem[l] = r_rem[j-1][l];
                assign w_q[l]   = r_q[j-1][l];
            end
        end

        assign w_dv = DR_W'(w_len) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[j]  <= w_len;
                r_side[j] <= w_side;
                for (int l = 0; l < 3; l++) begin
                    if (w_rem[l] >= w_dv) begin
                        r_rem[j][l] <= w_rem[l] - w_dv;
                        r_q[j][l]   <= w_q[l] | (Q_W'(1) << B);
                    end else begin
                        r_rem[j][l] <= w_rem[l];
                        r_q[j][l]   <= w_q[l];
                    end
                end
            end
        end
    end

    // clamp, sign, zero on failure
    logic [Q_W-1:0]   w_qc;
    logic [TAN_W-1:0] w_mg;
    logic [TAN_W-1:0] w_tan [3];
    t_out_item        n_out;
    t_out_item        r_out;
    logic             r_out_v;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_qc     = (r_q[Q_W-1][l] > ONE_Q) ? ONE_Q : r_q[Q_W-1][l];
            w_mg     = TAN_W'(w_qc);
            w_tan[l] = (r_side[Q_W-1].status != ST_OK) ? '0
                     : (r_side[Q_W-1].neg[l] ? (~w_mg + 1'b1) : w_mg);
        end
        n_out.tan_x  = w_tan[0];
        n_out.tan_y  = w_tan[1];
        n_out.tan_z  = w_tan[2];
        n_out.status = r_side[Q_W-1].status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

`default_nettype wire

/* rtl/core/tpte_checker.sv */
// port level checks for the tangent estimator, bound to the top level
// depends on tpte_pkg and three_point_tangent_estimator_core_defines.svh
`default_nettype none
`include "three_point_tangent_estimator_core_defines.svh"

module tpte_checker import tpte_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic w_stall;
    logic w_tan_zero;
    logic w_in_range;

    assign w_stall    = o_out_valid && !i_out_ready;
    assign w_tan_zero = o_out_data.tan_x == '0 && o_out_data.tan_y == '0
                     && o_out_data.tan_z == '0;
    assign w_in_range = o_out_data.tan_x <= TAN_ONE && o_out_data.tan_x >= TAN_MINUS_ONE
                     && o_out_data.tan_y <= TAN_ONE && o_out_data.tan_y >= TAN_MINUS_ONE
                     && o_out_data.tan_z <= TAN_ONE && o_out_data.tan_z >= TAN_MINUS_ONE;

    // a held result stays put
    `TPTE_ASSERT_NEXT(a_out_hold, w_stall, o_out_valid && $stable(o_out_data))

    // input is blocked only by a waiting result
    `TPTE_ASSERT_NOW(a_ready_stall, !o_in_ready, w_stall)

    // failed requests carry a zero tangent
    `TPTE_ASSERT_NOW(a_fail_zero, o_out_valid && o_out_data.status != ST_OK, w_tan_zero)

    // unit tangent components stay within one
    `TPTE_ASSERT_NOW(a_unit_range, o_out_valid && o_out_data.status == ST_OK, w_in_range)

endmodule

bind three_point_tangent_estimator_core tpte_checker u_tpte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

/* verif/testbench.sv */
// testbench for three_point_tangent_estimator_core: random and directed point triples,
// each result checked against an in-bench fixed-point tangent predictor
// depends on tpte_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
    import tpte_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);
    localparam longint unsigned Q30 = 64'd1 << 30;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    three_point_tangent_estimator_core dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [CFG_W-1:0] cur_min_len = MIN_LEN_RST;
    logic [CFG_W-1:0] cur_min_norm = MIN_NORM_RST;
    t_out_item        pending_tangents[$];
    int               errors = 0;
    bit               no_gaps = 1'b0;
    int               out_stall = 0;
    bit               took_result = 1'b0;

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint signed_as(longint r, longint unsigned m);
        return r < 0 ? -longint'(m) : longint'(m);
    endfunction

    // exact |v| < thr
    function automatic bit below_len(input longint v[3], input longint unsigned thr);
        longint unsigned s;
        longint unsigned m;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = absval(v[i]);
            if (m >= (64'd1 << 18)) return 1'b0;
            s += m * m;
        end
        return s < thr * thr;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit to_unit(input longint v[3], output longint res[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = absval(v[i]);
            if (m[i] > mx) mx = m[i];
            res[i] = 0;
        end
        if (mx == 0) return 1'b0;
        while (mx >= Q30) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (Q30 >> 1)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        len = floor_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] << 30) / len;
            if (q > Q30) q = Q30;
            res[i] = signed_as(v[i], q);
        end
        return 1'b1;
    endfunction

    function automatic t_out_item tangent_of(t_in_item p);
        longint p1[3], p2[3], p3[3];
        longint a[3], b[3], e[3], v[3], res[3], sa[3], sb[3];
        longint na, nb;
        longint unsigned mx;
        bit s1, s2, fail;
        int k;
        t_out_item o;
        p1 = '{longint'(p.p1_x), longint'(p.p1_y), longint'(p.p1_z)};
        p2 = '{longint'(p.p2_x), longint'(p.p2_y), longint'(p.p2_z)};
        p3 = '{longint'(p.p3_x), longint'(p.p3_y), longint'(p.p3_z)};
        for (int i = 0; i < 3; i++) begin
            a[i] = p2[i] - p1[i];
            b[i] = p3[i] - p2[i];
            e[i] = p3[i] - p1[i];
            res[i] = 0;
        end
        o = '0;
        s1 = below_len(a, cur_min_len);
        s2 = below_len(b, cur_min_len);
        if (s1 && s2) begin
            o.status = ST_BOTH_SHORT;
            return o;
        end
        if (s1) begin
            fail = below_len(e, cur_min_norm);
            v = e;
        end else if (s2) begin
            fail = below_len(a, cur_min_norm);
            v = a;
        end else begin
            fail = below_len(e, 2 * longint'(cur_min_norm));
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                if (absval(a[i]) > mx) mx = absval(a[i]);
                if (absval(b[i]) > mx) mx = absval(b[i]);
            end
            k = 0;
            while ((mx >> k) >= (64'd1 << 20)) k++;
            na = 0;
            nb = 0;
            for (int i = 0; i < 3; i++) begin
                sa[i] = signed_as(a[i], absval(a[i]) >> k);
                sb[i] = signed_as(b[i], absval(b[i]) >> k);
                na += sa[i] * sa[i];
                nb += sb[i] * sb[i];
            end
            for (int i = 0; i < 3; i++) v[i] = nb * sa[i] + na * sb[i];
        end
        if (fail || !to_unit(v, res)) begin
            o.status = ST_TOO_SHORT;
            return o;
        end
        o.status = ST_OK;
        o.tan_x = res[0][31:0];
        o.tan_y = res[1][31:0];
        o.tan_z = res[2][31:0];
        return o;
    endfunction

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    // drives one request; returns at the edge where it was accepted
    task automatic send_points(t_in_item p);
        repeat (draw_gap()) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = p;
        do @(posedge i_clk); while (!o_in_ready);
        pending_tangents.push_back(tangent_of(p));
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        release_input();
        wait (pending_tangents.size() == 0);
        repeat (80) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_MIN_LEN) cur_min_len = val;
        else if (idx == REG_MIN_NORM) cur_min_norm = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_in_item make_triple(logic signed [31:0] b1, logic signed [31:0] d1[3],
                                             logic signed [31:0] d2[3]);
        t_in_item p;
        p.p1_x = b1;
        p.p1_y = b1 ^ 32'h5a5a_a5a5;
        p.p1_z = ~b1;
        p.p2_x = p.p1_x + d1[0];
        p.p2_y = p.p1_y + d1[1];
        p.p2_z = p.p1_z + d1[2];
        p.p3_x = p.p2_x + d2[0];
        p.p3_y = p.p2_y + d2[1];
        p.p3_z = p.p2_z + d2[2];
        return p;
    endfunction

    function automatic logic signed [31:0] rand_offset();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic t_in_item random_triple();
        t_in_item p;
        logic signed [31:0] d1[3], d2[3];
        case ($urandom_range(0, 3))
            0: p = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
            default: begin
                for (int i = 0; i < 3; i++) begin
                    d1[i] = rand_offset();
                    d2[i] = rand_offset();
                end
                p = make_triple($urandom, d1, d2);
                p.p1_y = $urandom;
                p.p2_y = p.p1_y + d1[1];
                p.p3_y = p.p2_y + d2[1];
            end
        endcase
        return p;
    endfunction

    task automatic test_directed();
        logic signed [31:0] z[3], u[3], n[3];
        t_in_item p;
        z = '{0, 0, 0};
        u = '{32'sd65536, -32'sd3, 32'sd9};
        n = '{2, 1, 0};
        p = t_in_item'({9{32'h8000_0000}});
        send_points(p);
        p = t_in_item'({9{32'h7fff_ffff}});
        send_points(p);
        p = t_in_item'({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h8000_0000}}});
        send_points(p);
        p = t_in_item'({{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}});
        send_points(p);
        send_points(make_triple(32'sd100, n, n));         // both chords short
        send_points(make_triple(-32'sd7, n, u));          // first chord short
        send_points(make_triple(32'sd12345, u, n));       // second chord short
        send_points(make_triple(32'sd0, u, u));           // straight line
        send_points(make_triple(32'sd0, u, '{-32'sd65536, 32'sd3, -32'sd9})); // fold back
        send_points(make_triple(32'sd5, '{6, 0, 0}, '{7, 0, 0}));
        send_points(make_triple(32'sd5, '{3, 0, 0}, '{-3, 0, 0}));
        send_points(make_triple(32'sd1, '{32'sh4000_0000, 0, 0}, '{0, 32'sh4000_0000, 0}));
        send_points(make_triple(-32'sd1, '{1 << 20, -(1 << 19), 5}, '{-3, 1 << 21, -(1 << 20)}));
        send_points(make_triple(32'sd0, z, z));
        send_points(make_triple(32'sd0, '{8, 0, 0}, '{0, 0, 0}));
        send_points(make_triple(32'sd0, '{0, 0, 0}, '{0, 8, 0}));
        write_reg(REG_MIN_LEN, 16'd0);
        write_reg(REG_MIN_NORM, 16'd0);
        send_points(make_triple(32'sd77, z, z));          // zero direction
        send_points(make_triple(32'sd77, '{1, 0, 0}, '{-1, 0, 0}));
        write_reg(REG_MIN_LEN, 16'hffff);
        write_reg(REG_MIN_NORM, 16'hffff);
        send_points(make_triple(32'sd0, '{32'sd70000, 0, 0}, '{32'sd70000, 0, 0}));
        send_points(make_triple(32'sd0, '{32'sd70000, 0, 0}, '{-32'sd60000, 0, 0}));
        send_points(make_triple(32'sd0, n, '{32'sd65000, 0, 0}));
        send_points(make_triple(32'sd0, '{32'sd65536, 0, 0}, n));
        write_reg(REG_SPARE_2, 16'd3);                    // dropped
        write_reg(REG_SPARE_3, 16'd4);
        send_points(make_triple(32'sd0, '{32'sd70000, 0, 0}, n));
    endtask

    task automatic test_random_phase(logic [CFG_W-1:0] len, logic [CFG_W-1:0] nrm, int count);
        write_reg(REG_MIN_LEN, len);
        write_reg(REG_MIN_NORM, nrm);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
            send_points(random_triple());
        end
        no_gaps = 1'b0;
    endtask

    // result side: stall draw per result, with runs of no stall
    always @(negedge i_clk) begin
        if (took_result) out_stall = no_gaps ? 0 : $urandom_range(0, 11);
        if (out_stall > 0) begin
            i_out_ready = 1'b0;
            out_stall--;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        took_result = 1'b0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            took_result = 1'b1;
            if (pending_tangents.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                errors++;
            end else begin
                want = pending_tangents.pop_front();
                if (o_out_data.tan_x !== want.tan_x) begin
                    $display("%0t: tan_x expected %h actual %h", $time, want.tan_x,
                             o_out_data.tan_x);
                    errors++;
                end
                if (o_out_data.tan_y !== want.tan_y) begin
                    $display("%0t: tan_y expected %h actual %h", $time, want.tan_y,
                             o_out_data.tan_y);
                    errors++;
                end
                if (o_out_data.tan_z !== want.tan_z) begin
                    $display("%0t: tan_z expected %h actual %h", $time, want.tan_z,
                             o_out_data.tan_z);
                    errors++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_out_data.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_phase(MIN_LEN_RST, MIN_NORM_RST, 350);
        test_random_phase(16'd0, 16'd0, 350);
        test_random_phase(16'hffff, 16'hffff, 350);
        test_random_phase(16'($urandom), 16'($urandom), 350);
        test_random_phase(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 350);
        release_input();
        wait (pending_tangents.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
